FILE: sv/trajectory_setpoint_interpolator_core_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the trajectory setpoint interpolator
// Concurrent checks, compiled out when ASSERT_OFF is defined.
// ----------------------------------------------------------------------------
`ifndef TRAJECTORY_SETPOINT_INTERPOLATOR_CORE_DEFINES_SVH
`define TRAJECTORY_SETPOINT_INTERPOLATOR_CORE_DEFINES_SVH

`ifndef ASSERT_OFF
// same-cycle implication, sampled on clk, disabled in reset
`define TSPI_ASSERT_NOW(lbl, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("tspi assertion failed");
// next-cycle implication
`define TSPI_ASSERT_NEXT(lbl, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("tspi assertion failed");
`else
`define TSPI_ASSERT_NOW(lbl, pre, post)
`define TSPI_ASSERT_NEXT(lbl, pre, post)
`endif

`endif

FILE: sv/tspi_pkg.sv
// ----------------------------------------------------------------------------
// tspi_pkg
// Shared types and constants of the trajectory setpoint interpolator.
// ----------------------------------------------------------------------------
package tspi_pkg;

    localparam int T_W     = 16;   // point time, ms
    localparam int E_W     = 17;   // query time plus lookahead
    localparam int LA_W    = 10;   // lookahead register
    localparam int NUM_CH  = 8;    // interpolated channels
    localparam int CH_W    = 3;
    localparam int RATIO_W = 17;   // Q16 ratio, 0..65536
    localparam logic [RATIO_W-1:0] RATIO_ONE  = 17'h10000;
    localparam logic [CH_W-1:0]    CH_LAST    = 3'd7;
    localparam logic [LA_W-1:0]    LA_RESET   = 10'd50;

    // request transaction kinds
    localparam logic MODE_LOAD  = 1'b0;
    localparam logic MODE_QUERY = 1'b1;

    typedef logic signed [31:0] q16_t;

    // one stored horizon point; val[0..7] = vel xyz, acc xyz, yaw, yaw rate
    typedef struct packed {
        logic [T_W-1:0]    ptime;
        q16_t [NUM_CH-1:0] val;
    } point_t;

    typedef struct packed {
        logic           start;
        logic [T_W-1:0] num;
        logic [T_W-1:0] den;
    } div_req_t;

    typedef struct packed {
        logic           done;
        logic [T_W-1:0] quot;
    } div_rsp_t;

    typedef struct packed {
        logic               valid;
        logic [CH_W-1:0]    tag;
        q16_t               a;
        q16_t               b;
        logic [RATIO_W-1:0] ratio;
    } lerp_req_t;

    typedef struct packed {
        logic            valid;
        logic [CH_W-1:0] tag;
        q16_t            value;
    } lerp_rsp_t;

endpackage

FILE: sv/trajectory_setpoint_interpolator_core.sv
// ----------------------------------------------------------------------------
// trajectory_setpoint_interpolator_core
// Piecewise-linear sampling of a loaded trajectory horizon.
// ----------------------------------------------------------------------------
// A load transaction (mode 0) does not hold the request side, and loads may
// follow back to back. A query transaction (mode 1) holds the request side
// through these steps, N being the index of the point found: the linear scan
// reads the point memory through its single registered port, with a read
// state and a compare state per point (N + 1 points); the lower neighbour is
// read and captured; the ratio is checked; the restoring divider forms 16
// quotient bits and raises done; the shared three-stage multiply unit
// interpolates the eight channels one after another; the result is posted.
// When the ratio is 0 or 1 the divider is skipped. A query with fewer than
// two points stored goes straight to the finish state and returns valid_res
// 0 through the output register. A finished result waits in the output
// register, so loads are taken while it is not yet collected; a later query
// waits in its finish state until the register is free.
// ----------------------------------------------------------------------------
`include "trajectory_setpoint_interpolator_core_defines.svh"

module trajectory_setpoint_interpolator_core #(
    parameter int MAX_POINTS = 64
) (
    input  logic                 clk,
    input  logic                 rst_n,
    // configuration
    input  logic                 lookahead_we,
    input  logic [9:0]           lookahead_wdata,
    // request channel
    input  logic                 req_valid,
    output logic                 req_stall,
    input  logic                 mode,
    input  logic [15:0]          point_time,
    input  logic signed [31:0]   vel_x,
    input  logic signed [31:0]   vel_y,
    input  logic signed [31:0]   vel_z,
    input  logic signed [31:0]   acc_x,
    input  logic signed [31:0]   acc_y,
    input  logic signed [31:0]   acc_z,
    input  logic signed [31:0]   yaw_angle,
    input  logic signed [31:0]   yaw_speed,
    input  logic                 last_point,
    input  logic [15:0]          query_time,
    // result channel
    output logic                 res_valid,
    input  logic                 res_stall,
    output logic                 valid_res,
    output logic signed [31:0]   out_vel_x,
    output logic signed [31:0]   out_vel_y,
    output logic signed [31:0]   out_vel_z,
    output logic signed [31:0]   out_acc_x,
    output logic signed [31:0]   out_acc_y,
    output logic signed [31:0]   out_acc_z,
    output logic signed [31:0]   out_yaw,
    output logic signed [31:0]   out_yaw_rate
);

    localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int CW = $clog2(MAX_POINTS + 1);
    localparam int NC = tspi_pkg::NUM_CH;
    localparam int TW = tspi_pkg::T_W;
    localparam int EW = tspi_pkg::E_W;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SCAN_RD,
        S_SCAN_CMP,
        S_LO_RD,
        S_LO_CAP,
        S_RATIO,
        S_DIV,
        S_LERP,
        S_LWAIT,
        S_FINISH
    } state_t;

    state_t                           state_reg, state_next;
    logic [CW-1:0]                    count_reg, count_next;
    logic                             open_reg, open_next;
    logic [tspi_pkg::LA_W-1:0]        look_reg, look_next;
    logic [EW-1:0]                    elapsed_reg, elapsed_next;
    logic [AW-1:0]                    idx_reg, idx_next;
    tspi_pkg::point_t                 up_reg, up_next;
    tspi_pkg::point_t                 lo_reg, lo_next;
    logic [tspi_pkg::RATIO_W-1:0]     ratio_reg, ratio_next;
    logic [tspi_pkg::CH_W-1:0]        ch_reg, ch_next;
    logic                             wvalid_reg, wvalid_next;
    tspi_pkg::q16_t [NC-1:0]          work_reg, work_next;
    logic                             rvalid_reg, rvalid_next;
    logic                             vres_reg, vres_next;
    tspi_pkg::q16_t [NC-1:0]          out_reg, out_next;

    // store ports
    logic                             wr_en;
    logic [AW-1:0]                    wr_addr;
    tspi_pkg::point_t                 wr_data;
    logic [AW-1:0]                    rd_addr;
    tspi_pkg::point_t                 rd_data;

    tspi_pkg::div_req_t               div_req;
    tspi_pkg::div_rsp_t               div_rsp;
    tspi_pkg::lerp_req_t              lerp_req;
    tspi_pkg::lerp_rsp_t              lerp_rsp;

    logic                             accept;
    logic [CW-1:0]                    count_base;
    logic [AW-1:0]                    last_idx;
    logic                             hit;
    logic                             dur_pos;
    logic [TW-1:0]                    dur;
    logic signed [EW:0]               num;
    logic                             num_pos;
    logic                             num_ge;
    logic                             out_free;

    assign accept    = req_valid && !req_stall;
    assign req_stall = (state_reg != S_IDLE);
    assign out_free  = !rvalid_reg || !res_stall;

    // write path from the request fields
    assign count_base = open_reg ? count_reg : '0;
    assign wr_en      = accept && (mode == tspi_pkg::MODE_LOAD)
                        && (count_base < CW'(MAX_POINTS));
    assign wr_addr    = count_base[AW-1:0];
    always_comb
    begin
        wr_data.ptime  = point_time;
        wr_data.val[0] = vel_x;
        wr_data.val[1] = vel_y;
        wr_data.val[2] = vel_z;
        wr_data.val[3] = acc_x;
        wr_data.val[4] = acc_y;
        wr_data.val[5] = acc_z;
        wr_data.val[6] = yaw_angle;
        wr_data.val[7] = yaw_speed;
    end

    // read address: scan index, or the point below it
    assign rd_addr = (state_reg == S_LO_RD && idx_reg != '0) ? AW'(idx_reg - AW'(1))
                                                            : idx_reg;

    assign last_idx = AW'(count_reg - CW'(1));
    assign hit      = ({1'b0, rd_data.ptime} >= elapsed_reg) || (idx_reg == last_idx);

    // ratio classification
    assign dur_pos = up_reg.ptime > lo_reg.ptime;
    assign dur     = TW'(up_reg.ptime - lo_reg.ptime);
    assign num     = $signed({1'b0, elapsed_reg}) - $signed({2'b0, lo_reg.ptime});
    assign num_pos = !num[EW] && (num != '0);
    assign num_ge  = num[EW-1:0] >= {1'b0, dur};

    assign div_req.start = (state_reg == S_RATIO) && dur_pos && num_pos && !num_ge;
    assign div_req.num   = num[TW-1:0];
    assign div_req.den   = dur;

    assign lerp_req.valid = (state_reg == S_LERP);
    assign lerp_req.tag   = ch_reg;
    assign lerp_req.a     = lo_reg.val[ch_reg];
    assign lerp_req.b     = up_reg.val[ch_reg];
    assign lerp_req.ratio = ratio_reg;

    tspi_store #(
        .DEPTH (MAX_POINTS),
        .AW    (AW)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    tspi_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    tspi_lerp u_lerp (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (lerp_req),
        .rsp   (lerp_rsp)
    );

    // sequencer
    always_comb
    begin
        state_next   = state_reg;
        count_next   = count_reg;
        open_next    = open_reg;
        look_next    = lookahead_we ? lookahead_wdata : look_reg;
        elapsed_next = elapsed_reg;
        idx_next     = idx_reg;
        up_next      = up_reg;
        lo_next      = lo_reg;
        ratio_next   = ratio_reg;
        ch_next      = ch_reg;
        wvalid_next  = wvalid_reg;
        work_next    = work_reg;
        rvalid_next  = rvalid_reg && res_stall;
        vres_next    = vres_reg;
        out_next     = out_reg;

        if (lerp_rsp.valid)
        begin
            work_next[lerp_rsp.tag] = lerp_rsp.value;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept && mode == tspi_pkg::MODE_LOAD)
                begin
                    if (wr_en)
                    begin
                        count_next = count_base + CW'(1);
                    end
                    else
                    begin
                        count_next = count_base;
                    end
                    open_next = !last_point;
                end
                else if (accept)
                begin
                    elapsed_next = {1'b0, query_time} + EW'(look_reg);
                    idx_next     = '0;
                    if (count_reg < CW'(2))
                    begin
                        wvalid_next = 1'b0;
                        work_next   = '0;
                        state_next  = S_FINISH;
                    end
                    else
                    begin
                        wvalid_next = 1'b1;
                        state_next  = S_SCAN_RD;
                    end
                end
            end
            S_SCAN_RD:
            begin
                state_next = S_SCAN_CMP;
            end
            S_SCAN_CMP:
            begin
                if (hit)
                begin
                    up_next    = rd_data;
                    state_next = S_LO_RD;
                end
                else
                begin
                    idx_next   = AW'(idx_reg + AW'(1));
                    state_next = S_SCAN_RD;
                end
            end
            S_LO_RD:
            begin
                state_next = S_LO_CAP;
            end
            S_LO_CAP:
            begin
                lo_next    = rd_data;
                state_next = S_RATIO;
            end
            S_RATIO:
            begin
                ch_next = '0;
                priority if (!dur_pos || !num_pos)
                begin
                    ratio_next = '0;
                    state_next = S_LERP;
                end
                else if (num_ge)
                begin
                    ratio_next = tspi_pkg::RATIO_ONE;
                    state_next = S_LERP;
                end
                else
                begin
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                if (div_rsp.done)
                begin
                    ratio_next = {1'b0, div_rsp.quot};
                    state_next = S_LERP;
                end
            end
            S_LERP:
            begin
                ch_next = ch_reg + tspi_pkg::CH_W'(1);
                if (ch_reg == tspi_pkg::CH_LAST)
                begin
                    state_next = S_LWAIT;
                end
            end
            S_LWAIT:
            begin
                if (lerp_rsp.valid && lerp_rsp.tag == tspi_pkg::CH_LAST)
                begin
                    state_next = S_FINISH;
                end
            end
            S_FINISH:
            begin
                if (out_free)
                begin
                    rvalid_next = 1'b1;
                    vres_next   = wvalid_reg;
                    out_next    = work_reg;
                    state_next  = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            open_reg    <= 1'b0;
            look_reg    <= tspi_pkg::LA_RESET;
            elapsed_reg <= '0;
            idx_reg     <= '0;
            up_reg      <= '0;
            lo_reg      <= '0;
            ratio_reg   <= '0;
            ch_reg      <= '0;
            wvalid_reg  <= 1'b0;
            work_reg    <= '0;
            rvalid_reg  <= 1'b0;
            vres_reg    <= 1'b0;
            out_reg     <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            open_reg    <= open_next;
            look_reg    <= look_next;
            elapsed_reg <= elapsed_next;
            idx_reg     <= idx_next;
            up_reg      <= up_next;
            lo_reg      <= lo_next;
            ratio_reg   <= ratio_next;
            ch_reg      <= ch_next;
            wvalid_reg  <= wvalid_next;
            work_reg    <= work_next;
            rvalid_reg  <= rvalid_next;
            vres_reg    <= vres_next;
            out_reg     <= out_next;
        end
    end

    // result outputs
    assign res_valid    = rvalid_reg;
    assign valid_res    = vres_reg;
    assign out_vel_x    = out_reg[0];
    assign out_vel_y    = out_reg[1];
    assign out_vel_z    = out_reg[2];
    assign out_acc_x    = out_reg[3];
    assign out_acc_y    = out_reg[4];
    assign out_acc_z    = out_reg[5];
    assign out_yaw      = out_reg[6];
    assign out_yaw_rate = out_reg[7];

    // checks
    `TSPI_ASSERT_NOW(a_count_bound, 1'b1, count_reg <= CW'(MAX_POINTS))
    `TSPI_ASSERT_NOW(a_lerp_in_seq, lerp_rsp.valid, state_reg == S_LERP || state_reg == S_LWAIT)
    `TSPI_ASSERT_NOW(a_div_in_seq, div_rsp.done, state_reg == S_DIV)
    `TSPI_ASSERT_NEXT(a_finish_posts, state_reg == S_FINISH && !rvalid_reg, rvalid_reg)

endmodule

FILE: sv/tspi_store.sv
// ----------------------------------------------------------------------------
// tspi_store
// Horizon point memory: one write port, one registered read port.
// ----------------------------------------------------------------------------
module tspi_store #(
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  tspi_pkg::point_t wr_data,
    input  logic [AW-1:0]    rd_addr,
    output tspi_pkg::point_t rd_data
);

    tspi_pkg::point_t mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read
    always_ff @(posedge clk)
    begin
        rd_data <= mem[rd_addr];
    end

endmodule

FILE: sv/tspi_div.sv
// ----------------------------------------------------------------------------
// tspi_div
// Radix-2 restoring divider: quot = floor(num * 2^16 / den), num < den.
// ----------------------------------------------------------------------------
module tspi_div (
    input  logic               clk,
    input  logic               rst_n,
    input  tspi_pkg::div_req_t req,
    output tspi_pkg::div_rsp_t rsp
);

    localparam int N = tspi_pkg::T_W;
    localparam logic [4:0] STEPS = 5'(N);

    logic         busy_reg, busy_next;
    logic         done_reg, done_next;
    logic [4:0]   cnt_reg, cnt_next;
    logic [N-1:0] rem_reg, rem_next;
    logic [N-1:0] den_reg, den_next;
    logic [N-1:0] quot_reg, quot_next;
    logic [N:0]   shifted;
    logic         take;

    // one quotient bit per cycle
    always_comb
    begin
        shifted   = {rem_reg, 1'b0};
        take      = shifted >= {1'b0, den_reg};
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        quot_next = quot_reg;
        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = req.num;
            den_next  = req.den;
            quot_next = '0;
        end
        else if (busy_reg)
        begin
            rem_next  = take ? N'(shifted - {1'b0, den_reg}) : shifted[N-1:0];
            quot_next = {quot_reg[N-2:0], take};
            cnt_next  = cnt_reg + 5'd1;
            if (cnt_reg == STEPS - 5'd1)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
            rem_reg  <= '0;
            den_reg  <= '0;
            quot_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
            rem_reg  <= rem_next;
            den_reg  <= den_next;
            quot_reg <= quot_next;
        end
    end

    assign rsp.done = done_reg;
    assign rsp.quot = quot_reg;

endmodule

FILE: sv/tspi_lerp.sv
// ----------------------------------------------------------------------------
// tspi_lerp
// Shared interpolation unit: a + floor((b - a) * ratio / 2^16), 3 stages.
// ----------------------------------------------------------------------------
module tspi_lerp (
    input  logic                clk,
    input  logic                rst_n,
    input  tspi_pkg::lerp_req_t req,
    output tspi_pkg::lerp_rsp_t rsp
);

    localparam int RW = tspi_pkg::RATIO_W;

    logic                   v1_reg, v2_reg, v3_reg;
    logic [tspi_pkg::CH_W-1:0] t1_reg, t2_reg, t3_reg;
    tspi_pkg::q16_t         a1_reg, a2_reg, res_reg;
    logic signed [32:0]     diff_reg;
    logic [RW-1:0]          ratio_reg;
    logic signed [33+RW:0]  prod_reg;
    logic signed [32:0]     diff_next;
    logic signed [33+RW:0]  prod_next;
    tspi_pkg::q16_t         res_next;

    // difference, product, rounded-down add
    always_comb
    begin
        diff_next = $signed({req.b[31], req.b}) - $signed({req.a[31], req.a});
        prod_next = diff_reg * $signed({1'b0, ratio_reg});
        res_next  = a2_reg + tspi_pkg::q16_t'(prod_reg[47:16]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg    <= 1'b0;
            v2_reg    <= 1'b0;
            v3_reg    <= 1'b0;
            t1_reg    <= '0;
            t2_reg    <= '0;
            t3_reg    <= '0;
            a1_reg    <= '0;
            a2_reg    <= '0;
            res_reg   <= '0;
            diff_reg  <= '0;
            ratio_reg <= '0;
            prod_reg  <= '0;
        end
        else
        begin
            v1_reg    <= req.valid;
            t1_reg    <= req.tag;
            a1_reg    <= req.a;
            diff_reg  <= diff_next;
            ratio_reg <= req.ratio;
            v2_reg    <= v1_reg;
            t2_reg    <= t1_reg;
            a2_reg    <= a1_reg;
            prod_reg  <= prod_next;
            v3_reg    <= v2_reg;
            t3_reg    <= t2_reg;
            res_reg   <= res_next;
        end
    end

    assign rsp.valid = v3_reg;
    assign rsp.tag   = t3_reg;
    assign rsp.value = res_reg;

endmodule

FILE: sim/trajectory_setpoint_interpolator_core_tb.sv
// ----------------------------------------------------------------------------
// Testbench for trajectory_setpoint_interpolator_core
// Loads horizons of timed points and queries interpolated setpoints. A local
// model of the horizon store predicts every query result. The monitor checks
// the results in order, field by field; the sides idle at random, then never.
// ----------------------------------------------------------------------------
module trajectory_setpoint_interpolator_core_tb;

    localparam int   HZ_DEPTH     = 64;
    localparam int   LIMIT_CYCLES = 1_000_000;
    localparam int   SETTLE       = 40;

    // one request transaction as driven on the request channel
    typedef struct packed {
        logic                     mode;
        tspi_pkg::point_t         pt;
        logic                     last;
        logic [tspi_pkg::T_W-1:0] qtime;
    } req_item_t;

    // one result transaction; val[] in the same channel order as point_t
    typedef struct packed {
        logic                                  ok;
        tspi_pkg::q16_t [tspi_pkg::NUM_CH-1:0] val;
    } setpoint_t;

    // DUT inputs, all known from time zero
    logic                      clk             = 1'b0;
    logic                      rst_n           = 1'b0;
    logic                      lookahead_we    = 1'b0;
    logic [tspi_pkg::LA_W-1:0] lookahead_wdata = '0;
    logic                      req_valid       = 1'b0;
    logic                      res_stall       = 1'b0;
    req_item_t                 cur_item        = '0;

    logic                      mode;
    logic [tspi_pkg::T_W-1:0]  point_time;
    tspi_pkg::q16_t            vel_x, vel_y, vel_z, acc_x, acc_y, acc_z;
    tspi_pkg::q16_t            yaw_angle, yaw_speed;
    logic                      last_point;
    logic [tspi_pkg::T_W-1:0]  query_time;

    // DUT outputs
    logic                      req_stall;
    logic                      res_valid;
    logic                      valid_res;
    tspi_pkg::q16_t            out_vel_x, out_vel_y, out_vel_z;
    tspi_pkg::q16_t            out_acc_x, out_acc_y, out_acc_z;
    tspi_pkg::q16_t            out_yaw, out_yaw_rate;
    setpoint_t                 got_sp;

    // horizon model
    tspi_pkg::point_t          hz_pts [HZ_DEPTH];
    int unsigned               hz_count = 0;
    bit                        hz_open  = 1'b0;
    logic [tspi_pkg::LA_W-1:0] la_model = tspi_pkg::LA_RESET;

    // traffic bookkeeping
    req_item_t       req_backlog [$];
    setpoint_t       due_setpoints [$];
    setpoint_t       want_sp;
    logic            req_done     = 1'b0;
    int              n_issued     = 0;
    int              n_accepted   = 0;
    int              n_results    = 0;
    int              n_errors     = 0;
    int              n_cycles     = 0;
    int              src_idle_pct = 26;
    int              dst_idle_pct = 67;

    string ch_name [tspi_pkg::NUM_CH] = '{"out_vel_x", "out_vel_y", "out_vel_z",
                                          "out_acc_x", "out_acc_y", "out_acc_z",
                                          "out_yaw", "out_yaw_rate"};

    assign mode       = cur_item.mode;
    assign point_time = cur_item.pt.ptime;
    assign vel_x      = cur_item.pt.val[0];
    assign vel_y      = cur_item.pt.val[1];
    assign vel_z      = cur_item.pt.val[2];
    assign acc_x      = cur_item.pt.val[3];
    assign acc_y      = cur_item.pt.val[4];
    assign acc_z      = cur_item.pt.val[5];
    assign yaw_angle  = cur_item.pt.val[6];
    assign yaw_speed  = cur_item.pt.val[7];
    assign last_point = cur_item.last;
    assign query_time = cur_item.qtime;

    assign got_sp = {valid_res, out_yaw_rate, out_yaw, out_acc_z, out_acc_y, out_acc_x,
                     out_vel_z, out_vel_y, out_vel_x};

    trajectory_setpoint_interpolator_core #(
        .MAX_POINTS (HZ_DEPTH)
    ) dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .lookahead_we    (lookahead_we),
        .lookahead_wdata (lookahead_wdata),
        .req_valid       (req_valid),
        .req_stall       (req_stall),
        .mode            (mode),
        .point_time      (point_time),
        .vel_x           (vel_x),
        .vel_y           (vel_y),
        .vel_z           (vel_z),
        .acc_x           (acc_x),
        .acc_y           (acc_y),
        .acc_z           (acc_z),
        .yaw_angle       (yaw_angle),
        .yaw_speed       (yaw_speed),
        .last_point      (last_point),
        .query_time      (query_time),
        .res_valid       (res_valid),
        .res_stall       (res_stall),
        .valid_res       (valid_res),
        .out_vel_x       (out_vel_x),
        .out_vel_y       (out_vel_y),
        .out_vel_z       (out_vel_z),
        .out_acc_x       (out_acc_x),
        .out_acc_y       (out_acc_y),
        .out_acc_z       (out_acc_z),
        .out_yaw         (out_yaw),
        .out_yaw_rate    (out_yaw_rate)
    );

    always #4 clk = ~clk;

    // ------------------------------------------------------------------------
    // Model
    // ------------------------------------------------------------------------

    // a + floor((b - a) * ratio / 2^16); arithmetic shift floors
    function automatic tspi_pkg::q16_t lerp_q16(input tspi_pkg::q16_t a,
                                                input tspi_pkg::q16_t b,
                                                input longint ratio);
        longint prod;
        prod = (longint'(b) - longint'(a)) * ratio;
        return tspi_pkg::q16_t'(longint'(a) + (prod >>> 16));
    endfunction

    // apply one accepted transaction to the horizon; queries queue a setpoint
    task automatic horizon_step(input req_item_t it);
        logic [tspi_pkg::E_W-1:0] elapsed;
        int unsigned              up, lo;
        longint                   dur, num, ratio;
        setpoint_t                sp;
        if (it.mode == tspi_pkg::MODE_LOAD)
        begin
            // a load after a closed horizon starts a new one
            if (!hz_open)
            begin
                hz_count = 0;
                hz_open  = 1'b1;
            end
            // full horizon drops the point
            if (hz_count < HZ_DEPTH)
            begin
                hz_pts[hz_count] = it.pt;
                hz_count++;
            end
            if (it.last)
                hz_open = 1'b0;
        end
        else
        begin
            sp = '0;
            if (hz_count >= 2)
            begin
                sp.ok   = 1'b1;
                elapsed = it.qtime + la_model;
                // first point at or past elapsed, else the final point
                up = hz_count - 1;
                for (int i = 0; i < hz_count; i++)
                begin
                    if (hz_pts[i].ptime >= elapsed)
                    begin
                        up = i;
                        break;
                    end
                end
                lo    = (up > 0) ? up - 1 : 0;
                dur   = longint'(hz_pts[up].ptime) - longint'(hz_pts[lo].ptime);
                ratio = 0;
                if (dur > 0)
                begin
                    num = longint'(elapsed) - longint'(hz_pts[lo].ptime);
                    if (num > 0)
                    begin
                        ratio = (num * 65536) / dur;
                        if (ratio > 65536)
                            ratio = 65536;
                    end
                end
                for (int c = 0; c < tspi_pkg::NUM_CH; c++)
                    sp.val[c] = lerp_q16(hz_pts[lo].val[c], hz_pts[up].val[c], ratio);
            end
            due_setpoints.push_back(sp);
        end
    endtask

    task automatic flag_mismatch(input string msg);
        n_errors++;
        $display("MISMATCH result %0d: %s", n_results, msg);
    endtask

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------

    function automatic tspi_pkg::q16_t rand_q16();
        unique case ($urandom_range(11))
            0:       return tspi_pkg::q16_t'(32'h8000_0000);
            1:       return tspi_pkg::q16_t'(32'h7FFF_FFFF);
            2:       return '0;
            3:       return '1;
            default: return tspi_pkg::q16_t'($urandom);
        endcase
    endfunction

    function automatic tspi_pkg::point_t rand_point(input logic [tspi_pkg::T_W-1:0] t);
        tspi_pkg::point_t p;
        p.ptime = t;
        for (int c = 0; c < tspi_pkg::NUM_CH; c++)
            p.val[c] = rand_q16();
        return p;
    endfunction

    task automatic push_item(input req_item_t it);
        req_backlog.push_back(it);
        n_issued++;
    endtask

    task automatic push_load(input tspi_pkg::point_t p, input logic last);
        req_item_t it;
        it.mode  = tspi_pkg::MODE_LOAD;
        it.pt    = p;
        it.last  = last;
        it.qtime = tspi_pkg::T_W'($urandom);
        push_item(it);
    endtask

    task automatic push_load_fill(input logic [tspi_pkg::T_W-1:0] t,
                                  input tspi_pkg::q16_t v, input logic last);
        tspi_pkg::point_t p;
        p.ptime = t;
        p.val   = {tspi_pkg::NUM_CH{v}};
        push_load(p, last);
    endtask

    task automatic push_query(input logic [tspi_pkg::T_W-1:0] qt);
        req_item_t it;
        it.mode  = tspi_pkg::MODE_QUERY;
        it.pt    = rand_point(tspi_pkg::T_W'($urandom));
        it.last  = 1'($urandom);
        it.qtime = qt;
        push_item(it);
    endtask

    // query whose sampling time mostly lands around the span [t_lo, t_hi]
    task automatic push_query_near(input int t_lo, input int t_hi);
        int target, qt;
        if ($urandom_range(9) == 0)
        begin
            qt = $urandom_range(65535);
        end
        else
        begin
            target = $urandom_range(t_hi + 100, (t_lo > 50) ? t_lo - 50 : 0);
            qt     = target - int'(la_model);
            if (qt < 0)
                qt = 0;
            if (qt > 65535)
                qt = 65535;
        end
        push_query(tspi_pkg::T_W'(qt));
    endtask

    task automatic push_noise();
        req_item_t it;
        it.mode  = 1'($urandom);
        it.pt    = rand_point(tspi_pkg::T_W'($urandom));
        it.last  = 1'($urandom);
        it.qtime = tspi_pkg::T_W'($urandom);
        push_item(it);
    endtask

    // loads npts points with rising times, repeats and a saturating end
    task automatic gen_horizon(input int npts, input bit closed, input bit mid_q,
                               output int t_first, output int t_last);
        int t;
        t       = ($urandom_range(9) == 0) ? $urandom_range(65535) : $urandom_range(3000);
        t_first = t;
        t_last  = t;
        for (int k = 0; k < npts; k++)
        begin
            push_load(rand_point(tspi_pkg::T_W'(t)), closed && (k == npts - 1));
            t_last = t;
            if (mid_q && $urandom_range(7) == 0)
                push_query_near(t_first, t_last);
            t = t + (($urandom_range(9) == 0) ? 0 : $urandom_range(400, 1));
            if (t > 65535)
                t = 65535;
        end
    endtask

    // mostly complete horizons with queries; some open ones and noise
    task automatic gen_traffic(input int n_items);
        int stop_at, r, k, t_first, t_last;
        stop_at = n_issued + n_items;
        while (n_issued < stop_at)
        begin
            r = $urandom_range(99);
            if (r < 80)
            begin
                k = $urandom_range(99);
                if (k < 90)
                    k = $urandom_range(8, 2);
                else if (k < 97)
                    k = $urandom_range(40, 9);
                else
                    k = $urandom_range(70, 60);
                gen_horizon(k, 1'b1, 1'b1, t_first, t_last);
                repeat ($urandom_range(6, 1)) push_query_near(t_first, t_last);
            end
            else if (r < 90)
            begin
                gen_horizon($urandom_range(3, 1), 1'b0, 1'b0, t_first, t_last);
                repeat ($urandom_range(3, 1)) push_query_near(t_first, t_last);
            end
            else
            begin
                push_noise();
            end
        end
    endtask

    // wait until every transaction is taken and every result has come back
    task automatic drain_and_settle();
        do
            @(negedge clk);
        while (n_accepted != n_issued || due_setpoints.size() != 0);
        repeat (SETTLE) @(negedge clk);
    endtask

    task automatic write_lookahead(input logic [tspi_pkg::LA_W-1:0] v);
        @(negedge clk);
        lookahead_we    <= 1'b1;
        lookahead_wdata <= v;
        @(negedge clk);
        lookahead_we    <= 1'b0;
        la_model         = v;
    endtask

    // ------------------------------------------------------------------------
    // Driver: next transaction once the current one is taken
    // ------------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (rst_n && (!req_valid || req_done))
        begin
            if (req_backlog.size() != 0 && $urandom_range(99) >= src_idle_pct)
            begin
                cur_item  <= req_backlog.pop_front();
                req_valid <= 1'b1;
            end
            else
            begin
                req_valid <= 1'b0;
            end
        end
    end

    // result side back-pressure
    always @(negedge clk)
        res_stall <= ($urandom_range(99) < dst_idle_pct);

    // ------------------------------------------------------------------------
    // Monitor: check results, then feed accepted requests to the model
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (res_valid && !res_stall)
            begin
                if (due_setpoints.size() == 0)
                begin
                    flag_mismatch("result with no query outstanding");
                end
                else
                begin
                    want_sp = due_setpoints.pop_front();
                    if (got_sp.ok !== want_sp.ok)
                        flag_mismatch($sformatf("valid_res got %b expected %b",
                                                got_sp.ok, want_sp.ok));
                    for (int c = 0; c < tspi_pkg::NUM_CH; c++)
                        if (got_sp.val[c] !== want_sp.val[c])
                            flag_mismatch($sformatf("%s got %h expected %h", ch_name[c],
                                                    got_sp.val[c], want_sp.val[c]));
                end
                n_results++;
            end
            req_done <= req_valid && !req_stall;
            if (req_valid && !req_stall)
            begin
                horizon_step(cur_item);
                n_accepted++;
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        n_cycles++;
        if (n_cycles >= LIMIT_CYCLES)
        begin
            $display("timeout at cycle %0d", n_cycles);
            $display("end of test: mismatches");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------------
    initial
    begin
        repeat (12) @(negedge clk);
        rst_n <= 1'b1;

        // directed part, lookahead at its reset value of 50 ms
        push_query(16'd0);                               // nothing stored yet
        push_load_fill(16'd0, tspi_pkg::q16_t'(32'h7FFF_FFFF), 1'b0);
        push_query(16'd0);                               // one point, still loading
        push_load_fill(16'd100, tspi_pkg::q16_t'(32'h8000_0000), 1'b1);
        push_query(16'd0);                               // halfway, full-scale span
        push_query(16'd50);                              // exact hit on upper point
        push_query(16'hFFFF);                            // past the end, ratio clamps
        push_load(rand_point(16'hFFFF), 1'b0);           // closed horizon restarts
        push_query(16'd0);
        push_load(rand_point(16'hFFFF), 1'b0);           // repeated time
        push_query(16'd0);                               // zero duration
        push_load(rand_point(16'd10), 1'b1);             // time goes backward
        push_query(16'hFFFF);                            // negative duration
        push_query(16'd20);
        push_load(rand_point(16'd0), 1'b1);              // single-point horizon
        push_query(16'd1);
        drain_and_settle();

        // sender idles less than the receiver
        write_lookahead(10'd0);
        gen_traffic(360);
        drain_and_settle();

        // the other way round; starts with an overfull horizon
        src_idle_pct = 67;
        dst_idle_pct = 26;
        write_lookahead(10'd1000);
        begin : overfull
            int t_first, t_last;
            gen_horizon(67, 1'b1, 1'b0, t_first, t_last);
            repeat (6) push_query_near(t_first, t_last);
        end
        gen_traffic(290);
        drain_and_settle();

        // no idling at all
        src_idle_pct = 0;
        dst_idle_pct = 0;
        write_lookahead(10'd23);
        gen_traffic(180);
        drain_and_settle();
        write_lookahead(tspi_pkg::LA_W'($urandom_range(1000)));
        gen_traffic(180);
        drain_and_settle();

        if (n_errors == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
